FILE: rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the flow slice statistics unit.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int FLOWS    = 1024;
    localparam int FLOW_AW  = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    localparam int IN_W     = 64;   // 58 payload bits rounded up to bytes
    localparam int OUT_W    = 320;  // 314 payload bits rounded up to bytes
    localparam int CFG_W    = 16;

    localparam logic [CFG_W-1:0] SLICE_LENGTH_RESET = 16'd16;
    localparam logic [31:0]      GAP_NONE           = 32'hffff_ffff;

    // per-flow valid flags, kept in their own cleared memory
    typedef struct packed {
        logic slice;
        logic seen;
    } fss_flags_t;

    // per-flow statistics word
    typedef struct packed {
        logic [15:0] count;
        logic [31:0] bytes;
        logic [47:0] len_squares;
        logic [15:0] len_min;
        logic [15:0] len_max;
        logic [47:0] gap_total;
        logic [63:0] gap_squares;
        logic [31:0] gap_min;
        logic [31:0] gap_max;
        logic [31:0] last_time;
    } fss_entry_t;

    typedef struct packed {
        logic               accept;
        logic               clear_we;
        logic [FLOW_AW-1:0] clear_addr;
        logic               calc_gap;
        logic               calc_mul;
        logic               commit;
    } fss_cmd_t;

    typedef struct packed {
        logic in_range;
        logic emit;
        logic out_busy;
    } fss_status_t;

endpackage

FILE: rtl/fss_ctrl.sv
// ----------------------------------------------------------------------------
// fss_ctrl
// Sequencer: table clearing pass, then accept / gap / multiply / update.
// ----------------------------------------------------------------------------
module fss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fss_pkg::fss_status_t status,
    output fss_pkg::fss_cmd_t    cmd
);
    import fss_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GAP,
        ST_MUL,
        ST_UPD
    } state_t;

    state_t             state_reg;
    logic               s_tready_reg;
    logic [FLOW_AW-1:0] clr_addr_reg;

    logic accept;
    logic commit;

    assign accept = s_tvalid && s_tready_reg;
    assign commit = (state_reg == ST_UPD) && !(status.emit && status.out_busy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + FLOW_AW'(1);
                    if (clr_addr_reg == FLOW_AW'(FLOWS - 1))
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    // out-of-range flows are consumed and dropped here
                    if (accept && status.in_range)
                    begin
                        state_reg    <= ST_GAP;
                        s_tready_reg <= 1'b0;
                    end
                end
                ST_GAP:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (commit)
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_CLEAR;
                    s_tready_reg <= 1'b0;
                    clr_addr_reg <= '0;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;

    always_comb
    begin
        cmd.accept     = accept;
        cmd.clear_we   = (state_reg == ST_CLEAR);
        cmd.clear_addr = clr_addr_reg;
        cmd.calc_gap   = (state_reg == ST_GAP);
        cmd.calc_mul   = (state_reg == ST_MUL);
        cmd.commit     = commit;
    end

endmodule

FILE: rtl/fss_datapath.sv
// ----------------------------------------------------------------------------
// fss_datapath
// Flow tables, gap and square arithmetic, slice update and output register.
// ----------------------------------------------------------------------------
module fss_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [fss_pkg::IN_W-1:0]  s_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [fss_pkg::CFG_W-1:0] cfg_data,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [fss_pkg::OUT_W-1:0] m_tdata,
    input  fss_pkg::fss_cmd_t         cmd,
    output fss_pkg::fss_status_t      status
);
    import fss_pkg::*;

    fss_flags_t flags_mem [FLOWS];
    fss_entry_t entry_mem [FLOWS];

    logic [CFG_W-1:0]   slice_length_reg;

    logic [9:0]         in_flow;
    logic [15:0]        in_len;
    logic [31:0]        in_time;
    logic [FLOW_AW-1:0] in_addr;

    logic [9:0]         flow_reg;
    logic [FLOW_AW-1:0] addr_reg;
    logic [15:0]        len_reg;
    logic [31:0]        now_reg;
    fss_flags_t         rd_flags_reg;
    fss_entry_t         rd_entry_reg;
    logic [31:0]        gap_reg;
    logic [31:0]        len_sq_reg;
    logic [63:0]        gap_sq_reg;

    fss_entry_t         new_entry;
    fss_flags_t         new_flags;
    logic               emit;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    assign in_flow = s_tdata[9:0];
    assign in_len  = s_tdata[25:10];
    assign in_time = s_tdata[57:26];
    assign in_addr = FLOW_AW'(in_flow);

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_length_reg <= SLICE_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            slice_length_reg <= cfg_data;
        end
    end

    // capture and table read
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            flow_reg     <= in_flow;
            addr_reg     <= in_addr;
            len_reg      <= in_len;
            now_reg      <= in_time;
            rd_flags_reg <= flags_mem[in_addr];
            rd_entry_reg <= entry_mem[in_addr];
        end
    end

    // table write: clearing pass or slice commit
    always_ff @(posedge clk)
    begin
        if (cmd.clear_we)
        begin
            flags_mem[cmd.clear_addr] <= '0;
        end
        else if (cmd.commit)
        begin
            flags_mem[addr_reg] <= new_flags;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            entry_mem[addr_reg] <= new_entry;
        end
    end

    // gap and squares
    always_ff @(posedge clk)
    begin
        if (cmd.calc_gap)
        begin
            gap_reg    <= rd_flags_reg.seen ? (now_reg - rd_entry_reg.last_time) : 32'd0;
            len_sq_reg <= 32'(len_reg) * 32'(len_reg);
        end
        if (cmd.calc_mul)
        begin
            gap_sq_reg <= 64'(gap_reg) * 64'(gap_reg);
        end
    end

    // slice update
    always_comb
    begin
        new_entry           = rd_entry_reg;
        new_entry.last_time = now_reg;
        if (rd_flags_reg.slice)
        begin
            new_entry.count       = rd_entry_reg.count + 16'd1;
            new_entry.bytes       = rd_entry_reg.bytes + 32'(len_reg);
            new_entry.len_squares = rd_entry_reg.len_squares + 48'(len_sq_reg);
            if (len_reg < rd_entry_reg.len_min)
            begin
                new_entry.len_min = len_reg;
            end
            if (len_reg > rd_entry_reg.len_max)
            begin
                new_entry.len_max = len_reg;
            end
            new_entry.gap_total   = rd_entry_reg.gap_total + 48'(gap_reg);
            new_entry.gap_squares = rd_entry_reg.gap_squares + gap_sq_reg;
            if (gap_reg < rd_entry_reg.gap_min)
            begin
                new_entry.gap_min = gap_reg;
            end
            if (gap_reg > rd_entry_reg.gap_max)
            begin
                new_entry.gap_max = gap_reg;
            end
        end
        else
        begin
            // slice start: gap left out
            new_entry.count       = 16'd1;
            new_entry.bytes       = 32'(len_reg);
            new_entry.len_squares = 48'(len_sq_reg);
            new_entry.len_min     = len_reg;
            new_entry.len_max     = len_reg;
            new_entry.gap_total   = '0;
            new_entry.gap_squares = '0;
            new_entry.gap_min     = GAP_NONE;
            new_entry.gap_max     = '0;
        end
        emit            = (new_entry.count >= slice_length_reg);
        new_flags.seen  = 1'b1;
        new_flags.slice = !emit;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && emit)
        begin
            out_data_reg <= {6'd0,
                             new_entry.gap_max,
                             new_entry.gap_min,
                             new_entry.gap_squares,
                             new_entry.gap_total,
                             new_entry.len_max,
                             new_entry.len_min,
                             new_entry.len_squares,
                             new_entry.bytes,
                             new_entry.count,
                             flow_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        status.in_range = (32'(in_flow) < 32'(FLOWS));
        status.emit     = emit;
        status.out_busy = out_valid_reg && !m_tready;
    end

endmodule

FILE: rtl/flow_slice_statistics_unit.sv
// ----------------------------------------------------------------------------
// flow_slice_statistics_unit
// Per-flow packet statistics over fixed-size slices, one record per slice.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            payload
//  -------   ---   ------------------   --------------------------------------
//  s_*       in    s_tvalid/s_tready    packet: flow, length, timestamp
//  m_*       out   m_tvalid/m_tready    completed slice record
//  cfg_*     in    cfg_valid/cfg_ready  slice_length (always ready)
//
//  An in-range packet steps through accept with table read, gap and
//  length square, gap square (32x32 multiplier), update and table write.
//  An out-of-range flow index is accepted and dropped from the idle state.
//  After reset a clearing pass over all FLOWS (1024) entries zeroes the flag table;
//  s_tready stays low meanwhile. Config writes are taken at any time.
//  A record waits in the output register; a packet that completes a slice
//  while that register is still held stalls in its update step.
//
module flow_slice_statistics_unit (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [9:0] flow_index, [25:10] packet_length, [57:26] timestamp_us, rest 0
    input  logic [fss_pkg::IN_W-1:0]  s_tdata,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [9:0] out_flow_index, [25:10] packet_count, [57:26] byte_sum,
    // [105:58] length_square_sum, [121:106] length_min, [137:122] length_max,
    // [185:138] gap_sum, [249:186] gap_square_sum, [281:250] gap_min,
    // [313:282] gap_max, rest 0
    output logic [fss_pkg::OUT_W-1:0] m_tdata,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [fss_pkg::CFG_W-1:0] cfg_data     // slice_length
);
    import fss_pkg::*;

    fss_cmd_t    cmd;
    fss_status_t status;

    // sequencer
    fss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, arithmetic, output register
    fss_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTHESIS
    // one packet in flight: an in-range transaction drops ready next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && status.in_range) |=> !s_tready)
        else $error("input accepted while a packet is in flight");

    // a record is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && status.emit) |-> !status.out_busy)
        else $error("output record overwritten");

    // no packet accepted during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_we |-> !s_tready)
        else $error("input ready during table clear");

    // table write and clearing pass never coincide
    a_clear_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_we && cmd.commit))
        else $error("commit during table clear");
`endif

endmodule
